FILE: rtl/ip_blacklist_filter_table_macros.svh
// Assertion macros shared by the blacklist filter table RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef IP_BLACKLIST_FILTER_TABLE_MACROS_SVH
`define IP_BLACKLIST_FILTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ipbf_pkg.sv
// Package for the IPv4 blacklist filter table: sizes, codes and the
// controller to datapath command and status types. Depends on nothing.
package ipbf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int ECNT_W      = 5;

    typedef enum logic [1:0] {
        MODE_CHECK  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STATUS_DONE    = 3'd0,
        STATUS_BLOCKED = 3'd1,
        STATUS_PRESENT = 3'd2,
        STATUS_ABSENT  = 3'd3,
        STATUS_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic take_item;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

    // The reported count keeps only its low five bits.
    function automatic logic [ECNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[ECNT_W-1:0];
    endfunction

endpackage

FILE: rtl/ipbf_if.sv
// Handshake interfaces for the blacklist filter table: the input word
// channel and the result word channel. Depends on ipbf_pkg.
interface ipbf_item_if
    import ipbf_pkg::*;
();
    logic                valid;
    logic                ready;
    t_mode               mode;
    logic [ADDR_W-1:0]   ip_address;

    modport source (output valid, output mode, output ip_address, input ready);
    modport sink   (input valid, input mode, input ip_address, output ready);
endinterface

interface ipbf_result_if
    import ipbf_pkg::*;
();
    logic                valid;
    logic                ready;
    t_status             status;
    logic [ECNT_W-1:0]   entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

FILE: rtl/ipbf_ctrl.sv
// Controller state machine of the blacklist filter table: walks the table
// once per word and sequences the commit. Depends on ipbf_pkg.
module ipbf_ctrl
    import ipbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.take_item = 1'b0;
        o_cmd.scan      = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/ipbf_datapath.sv
// Datapath of the blacklist filter table: address memory, valid bits,
// entry count, scan compare and the result register. Depends on ipbf_pkg,
// ipbf_if and the assertion macro header.
`include "ip_blacklist_filter_table_macros.svh"

module ipbf_datapath
    import ipbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  t_mode             i_mode,
    input  logic [ADDR_W-1:0] i_ip_address,
    ipbf_result_if.source     o_result
);

    logic [ADDR_W-1:0]      r_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]      r_rd_data;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_scan_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    t_mode                  r_item_mode;
    logic [ADDR_W-1:0]      r_item_addr;
    logic                   r_match_found;
    logic [IDX_W-1:0]       r_match_idx;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ECNT_W-1:0]      r_out_count;

    logic                   cmp_hit;
    logic                   cmp_free;
    t_status                n_status;
    logic [CNT_W-1:0]       n_count;
    logic                   do_write;
    logic                   do_clear_slot;
    logic                   do_clear_all;

    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data == r_item_addr);
    assign cmp_free = r_cmp_vld && !r_valid[r_cmp_idx];

    assign o_sts.scan_last = (r_scan_idx == IDX_W'(TABLE_DEPTH - 1));
    assign o_sts.out_free  = !r_out_valid || o_result.ready;

    // The memory has one read port, walked one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
        if (i_cmd.commit && do_write) begin
            r_mem[r_free_idx] <= r_item_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_idx;
        end
        if (i_cmd.take_item) begin
            r_item_mode <= i_mode;
            r_item_addr <= i_ip_address;
        end
        if (cmp_hit && !r_match_found) begin
            r_match_idx <= r_cmp_idx;
        end
        if (cmp_free && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_count  <= to_entry_count(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld     <= 1'b0;
            r_scan_idx    <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.take_item) begin
                r_scan_idx    <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                end
                if (cmp_hit) begin
                    r_match_found <= 1'b1;
                end
                if (cmp_free) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_status      = STATUS_DONE;
        n_count       = r_count;
        do_write      = 1'b0;
        do_clear_slot = 1'b0;
        do_clear_all  = 1'b0;
        unique case (r_item_mode)
            MODE_CHECK: begin
                if (r_match_found) begin
                    n_status = STATUS_BLOCKED;
                end
            end
            MODE_ADD: begin
                if (r_match_found) begin
                    n_status = STATUS_PRESENT;
                end else if (!r_free_found) begin
                    n_status = STATUS_FULL;
                end else begin
                    do_write = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (!r_match_found) begin
                    n_status = STATUS_ABSENT;
                end else begin
                    do_clear_slot = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            MODE_CLEAR: begin
                do_clear_all = 1'b1;
                n_count      = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (do_clear_all) begin
                    r_valid <= '0;
                end else if (do_write) begin
                    r_valid[r_free_idx] <= 1'b1;
                end else if (do_clear_slot) begin
                    r_valid[r_match_idx] <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.entry_count = r_out_count;

    `IPBF_ASSERT_IMP(a_count_matches_valid, i_clk, i_rst_n, 1'b1,
        $countones(r_valid) == 32'(r_count), "entry count disagrees with valid bits")
    `IPBF_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1,
        32'(r_count) <= TABLE_DEPTH, "entry count exceeds table depth")
    `IPBF_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n,
        i_cmd.commit && (r_item_mode == MODE_CLEAR), r_valid == '0,
        "table not empty after clear")

endmodule

FILE: rtl/ip_blacklist_filter_table.sv
// IPv4 destination blacklist filter table. Each accepted word is handled
// alone: the 16-entry address memory is read through its single port one
// entry per cycle, then a drain state finishes the last compare and a
// finish state commits the table update and loads the result register;
// only then is the next word accepted. The result stays in an output
// register until taken and a stalled result holds the commit. Depends on
// ipbf_pkg, ipbf_if, ipbf_ctrl and ipbf_datapath.
module ip_blacklist_filter_table
    import ipbf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipbf_item_if.sink     i_item,
    ipbf_result_if.source o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_item.ready = in_ready;

    ipbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ipbf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_item.mode),
        .i_ip_address (i_item.ip_address),
        .o_result     (o_result)
    );

endmodule
